// ===== rtl/edfw_pkg.sv =====
// ----------------------------------------------------------------------------
// edfw_pkg
// Shared constants and controller/datapath interface types for the
// earliest-free worker dispatcher.
// ----------------------------------------------------------------------------
package edfw_pkg;

    localparam int unsigned MaxWorkersDef   = 64;
    localparam int unsigned TimeWidthDef    = 48;
    localparam int unsigned CfgWidth        = 7;
    localparam int unsigned NumWorkersReset = 64;
    localparam int unsigned DurWidth        = 32;
    localparam int unsigned IdxOutWidth     = 6;
    localparam int unsigned StartWidth      = 48;

    // controller -> datapath
    typedef struct packed {
        logic cfg_load;   // take new worker count, restart clear pass
        logic clr_wr;     // write one reset entry, advance clear counter
        logic dur_load;   // latch job duration
        logic rd_root;    // read heap entry 0
        logic take_root;  // capture result, build the new root item
        logic sift_step;  // compare with children, write one level
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;   // clear counter on the last entry
        logic sift_more;  // a child moved up, keep going down
    } t_status;

endpackage

// ===== rtl/earliest_free_worker_dispatcher.sv =====
// A result is read from heap entry 0 and registered once the output is free.
// One item is handled at a time: the next is accepted only after the new root
// sinks m levels (m <= floor(log2(workers))); each level costs one registered
// heap read and one compare/write.
// Reset and every worker count write start a clear pass over all MAX_WORKERS
// heap entries, one entry per cycle, during which no item is accepted.
// ----------------------------------------------------------------------------
// earliest_free_worker_dispatcher
// Hands each job to the worker that frees earliest, using a binary min-heap
// of (free time, worker) pairs with a sequential sift-down.
// ----------------------------------------------------------------------------
module earliest_free_worker_dispatcher #(
    parameter int unsigned MAX_WORKERS = edfw_pkg::MaxWorkersDef,
    parameter int unsigned TIME_WIDTH  = edfw_pkg::TimeWidthDef
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [edfw_pkg::CfgWidth-1:0]    i_cfg_num_workers,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [edfw_pkg::DurWidth-1:0]    i_job_duration,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [edfw_pkg::IdxOutWidth-1:0] o_worker_index,
    output logic [edfw_pkg::StartWidth-1:0]  o_start_time
);

    edfw_pkg::t_cmd    cmd;
    edfw_pkg::t_status status;

    edfw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    edfw_dp #(
        .MAX_WORKERS (MAX_WORKERS),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_data     (i_cfg_num_workers),
        .i_job_duration (i_job_duration),
        .o_worker_index (o_worker_index),
        .o_start_time   (o_start_time)
    );

endmodule

// ===== rtl/edfw_ctrl.sv =====
// ----------------------------------------------------------------------------
// edfw_ctrl
// Sequencer: clear pass, root read, result handoff and sift-down levels.
// ----------------------------------------------------------------------------
module edfw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output edfw_pkg::t_cmd    o_cmd,
    input  edfw_pkg::t_status i_status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_READ,
        ST_CMP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   cfg_fire, in_fire, out_free;
    edfw_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    // a worker count write restarts the heap, so no item is taken with it
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        cmd          = '0;
        cmd.cfg_load = cfg_fire;
        n_state      = r_state;
        case (r_state)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.dur_load = in_fire;
                cmd.rd_root  = in_fire;
                if (in_fire) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                // hold the root read until the output register is free
                cmd.take_root = out_free;
                cmd.rd_root   = !out_free;
                if (out_free) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                cmd.sift_step = 1'b1;
                n_state = i_status.sift_more ? ST_READ : ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        if (cfg_fire) begin
            n_state = ST_CLEAR;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.take_root) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/edfw_dp.sv =====
// ----------------------------------------------------------------------------
// edfw_dp
// Heap memory, worker count, carried item and compare/select logic.
// ----------------------------------------------------------------------------
module edfw_dp #(
    parameter int unsigned MAX_WORKERS = edfw_pkg::MaxWorkersDef,
    parameter int unsigned TIME_WIDTH  = edfw_pkg::TimeWidthDef
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  edfw_pkg::t_cmd                      i_cmd,
    output edfw_pkg::t_status                   o_status,
    input  logic [edfw_pkg::CfgWidth-1:0]       i_cfg_data,
    input  logic [edfw_pkg::DurWidth-1:0]       i_job_duration,
    output logic [edfw_pkg::IdxOutWidth-1:0]    o_worker_index,
    output logic [edfw_pkg::StartWidth-1:0]     o_start_time
);

    localparam int unsigned AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int unsigned CW = AW + 2;
    localparam int unsigned EW = TIME_WIDTH + AW;
    localparam int unsigned SW = TIME_WIDTH + 1;

    logic [EW-1:0] r_mem [MAX_WORKERS];

    logic [edfw_pkg::CfgWidth-1:0]    r_num;
    logic [AW-1:0]                    r_clr_cnt;
    logic [edfw_pkg::DurWidth-1:0]    r_dur;
    logic [TIME_WIDTH-1:0]            r_cur_time;
    logic [AW-1:0]                    r_cur_id;
    logic [AW-1:0]                    r_pos;
    logic [EW-1:0]                    r_rd0, r_rd1;
    logic [edfw_pkg::IdxOutWidth-1:0] r_out_idx;
    logic [edfw_pkg::StartWidth-1:0]  r_out_start;

    logic [CW-1:0]         count, lo, hi;
    logic                  lo_ok, hi_ok;
    logic [AW-1:0]         lo_addr, hi_addr, rd_addr0;
    logic [TIME_WIDTH-1:0] lo_t, hi_t, root_t;
    logic [AW-1:0]         lo_w, hi_w, root_w;
    logic                  lo_lt_cur, hi_lt_cur, hi_lt_lo;
    logic                  lo_sel, hi_sel, move;
    logic [EW-1:0]         wdata;
    logic [AW-1:0]         child_pos;
    logic [SW-1:0]         sum;

    // active worker count: zero acts as one, clamp at the heap size
    always_comb begin
        if (r_num == '0) begin
            count = CW'(1);
        end else if (32'(r_num) > 32'(MAX_WORKERS)) begin
            count = CW'(MAX_WORKERS);
        end else begin
            count = CW'(r_num);
        end
    end

    assign lo      = {1'b0, r_pos, 1'b1};
    assign hi      = {1'b0, r_pos, 1'b0} + CW'(2);
    assign lo_ok   = (lo < count);
    assign hi_ok   = (hi < count);
    assign lo_addr = lo_ok ? lo[AW-1:0] : '0;
    assign hi_addr = hi_ok ? hi[AW-1:0] : '0;
    assign rd_addr0 = i_cmd.rd_root ? '0 : lo_addr;

    assign lo_t   = r_rd0[EW-1:AW];
    assign lo_w   = r_rd0[AW-1:0];
    assign hi_t   = r_rd1[EW-1:AW];
    assign hi_w   = r_rd1[AW-1:0];
    assign root_t = r_rd0[EW-1:AW];
    assign root_w = r_rd0[AW-1:0];

    // order is (time, worker)
    assign lo_lt_cur = (lo_t < r_cur_time) || ((lo_t == r_cur_time) && (lo_w < r_cur_id));
    assign hi_lt_cur = (hi_t < r_cur_time) || ((hi_t == r_cur_time) && (hi_w < r_cur_id));
    assign hi_lt_lo  = (hi_t < lo_t) || ((hi_t == lo_t) && (hi_w < lo_w));

    assign lo_sel    = lo_ok && lo_lt_cur;
    assign hi_sel    = hi_ok && (lo_sel ? hi_lt_lo : hi_lt_cur);
    assign move      = lo_sel || hi_sel;
    assign child_pos = hi_sel ? hi[AW-1:0] : lo[AW-1:0];
    assign wdata     = hi_sel ? r_rd1 : (lo_sel ? r_rd0 : {r_cur_time, r_cur_id});

    assign sum = {1'b0, root_t} + SW'(r_dur);

    assign o_status.clr_last  = (r_clr_cnt == AW'(MAX_WORKERS - 1));
    assign o_status.sift_more = move;
    assign o_worker_index     = r_out_idx;
    assign o_start_time       = r_out_start;

    // heap memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_cnt] <= {{TIME_WIDTH{1'b0}}, r_clr_cnt};
        end else if (i_cmd.sift_step) begin
            r_mem[r_pos] <= wdata;
        end
        r_rd0 <= r_mem[rd_addr0];
        r_rd1 <= r_mem[hi_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num     <= edfw_pkg::CfgWidth'(edfw_pkg::NumWorkersReset);
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.cfg_load) begin
                r_num     <= i_cfg_data;
                r_clr_cnt <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dur_load) begin
            r_dur <= i_job_duration;
        end
        if (i_cmd.take_root) begin
            r_out_idx   <= edfw_pkg::IdxOutWidth'(root_w);
            r_out_start <= edfw_pkg::StartWidth'(root_t);
            r_cur_time  <= sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
            r_cur_id    <= root_w;
            r_pos       <= '0;
        end else if (i_cmd.sift_step && move) begin
            r_pos <= child_pos;
        end
    end

endmodule
